// File: src/brbc_pkg.sv
// Shared types and constants for the bounded retry backoff controller.
// Holds event, action, reason and phase codes and the result struct.
// No dependencies.
package brbc_pkg;

	localparam int MODE_W   = 3;
	localparam int ACTION_W = 3;
	localparam int REASON_W = 5;
	localparam int PHASE_W  = 2;
	localparam int EPOCH_W  = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_OBSERVE  = 3'd0,
		MODE_ARM      = 3'd1,
		MODE_TICK     = 3'd2,
		MODE_COMPLETE = 3'd3,
		MODE_CANCEL   = 3'd4,
		MODE_RESET    = 3'd5
	} mode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_REJECT  = 3'd1,
		ACT_CANCEL  = 3'd2,
		ACT_HOLD    = 3'd3,
		ACT_CONSUME = 3'd4,
		ACT_START   = 3'd5,
		ACT_IGNORE  = 3'd6
	} action_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 2'd0,
		PH_BACKOFF = 2'd1,
		PH_FLIGHT  = 2'd2,
		PH_SPENT   = 2'd3
	} phase_t;

	typedef enum logic [REASON_W-1:0] {
		RSN_NONE              = 5'd0,
		RSN_INVALID_GOAL      = 5'd1,
		RSN_NEW_GOAL          = 5'd2,
		RSN_SUPERSEDED        = 5'd3,
		RSN_MAP_CHANGED       = 5'd4,
		RSN_MAP_ADVANCED      = 5'd5,
		RSN_EPOCH_CHANGED     = 5'd6,
		RSN_EPOCH_ADVANCED    = 5'd7,
		RSN_UNCHANGED         = 5'd8,
		RSN_STALE_EPOCH       = 5'd9,
		RSN_STALE_MAP         = 5'd10,
		RSN_BACKOFF_ALREADY   = 5'd11,
		RSN_FLIGHT_ALREADY    = 5'd12,
		RSN_BUDGET_CONSUMED   = 5'd13,
		RSN_STOP_UNCONFIRMED  = 5'd14,
		RSN_DEADLINE_OVERFLOW = 5'd15,
		RSN_BACKOFF_PENDING   = 5'd16,
		RSN_TICK_UNKNOWN      = 5'd17,
		RSN_NO_PENDING        = 5'd18,
		RSN_START_ALREADY     = 5'd19,
		RSN_START_REPLAN      = 5'd20,
		RSN_STALE_COMPLETION  = 5'd21,
		RSN_COMPLETED         = 5'd22,
		RSN_FAILED            = 5'd23,
		RSN_CANCEL_UNKNOWN    = 5'd24,
		RSN_CANCELLED         = 5'd25,
		RSN_CLOCK_REGRESSION  = 5'd26
	} reason_t;

	typedef struct packed {
		action_t action;
		reason_t reason;
		phase_t  phase;
		logic    budget_used;
		logic    start_sent;
	} rslt_t;

endpackage

// File: src/brbc_if.sv
// Handshake channels of the bounded retry backoff controller.
// Event request, result and configuration write channels; depends on brbc_pkg.
interface brbc_event_if #(
	parameter int ID_WIDTH   = 32,
	parameter int TIME_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [brbc_pkg::MODE_W-1:0]   mode;
	logic [ID_WIDTH-1:0]           task_key;
	logic [ID_WIDTH-1:0]           request_key;
	logic [brbc_pkg::EPOCH_W-1:0]  goal_epoch;
	logic [ID_WIDTH-1:0]           map_key;
	logic                          map_key_valid;
	logic [TIME_WIDTH-1:0]         now_ticks;
	logic                          event_flag;

	modport source(output valid, mode, task_key, request_key, goal_epoch, map_key,
		map_key_valid, now_ticks, event_flag, input ready);
	modport sink(input valid, mode, task_key, request_key, goal_epoch, map_key,
		map_key_valid, now_ticks, event_flag, output ready);
endinterface

interface brbc_result_if;
	logic                           valid;
	logic                           ready;
	logic [brbc_pkg::ACTION_W-1:0]  action;
	logic [brbc_pkg::REASON_W-1:0]  reason_code;
	logic [brbc_pkg::PHASE_W-1:0]   replan_state;
	logic                           budget_used;
	logic                           start_sent;

	modport source(output valid, action, reason_code, replan_state, budget_used,
		start_sent, input ready);
	modport sink(input valid, action, reason_code, replan_state, budget_used,
		start_sent, output ready);
endinterface

interface brbc_cfg_if #(
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] backoff_ticks;

	modport source(output valid, backoff_ticks, input ready);
	modport sink(input valid, backoff_ticks, output ready);
endinterface

// File: src/brbc_in_stage.sv
// Input register stage of the bounded retry backoff controller.
// Captures one event request per cycle while not stalled; depends on brbc_pkg.
module brbc_in_stage #(
	parameter int ID_WIDTH   = 32,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [brbc_pkg::MODE_W-1:0]   in_mode,
	input  logic [ID_WIDTH-1:0]           in_task,
	input  logic [ID_WIDTH-1:0]           in_request,
	input  logic [brbc_pkg::EPOCH_W-1:0]  in_epoch,
	input  logic [ID_WIDTH-1:0]           in_map,
	input  logic                          in_map_ok,
	input  logic [TIME_WIDTH-1:0]         in_now,
	input  logic                          in_flag,
	input  logic                          step,
	output logic                          valid_s1,
	output logic [brbc_pkg::MODE_W-1:0]   mode_s1,
	output logic [ID_WIDTH-1:0]           task_s1,
	output logic [ID_WIDTH-1:0]           request_s1,
	output logic [brbc_pkg::EPOCH_W-1:0]  epoch_s1,
	output logic [ID_WIDTH-1:0]           map_s1,
	output logic                          map_ok_s1,
	output logic [TIME_WIDTH-1:0]         now_s1,
	output logic                          flag_s1
);
	import brbc_pkg::*;

	logic load;

	// Take a new request when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || step;
	assign load     = in_valid && in_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (load) begin
			mode_s1    <= in_mode;
			task_s1    <= in_task;
			request_s1 <= in_request;
			epoch_s1   <= in_epoch;
			map_s1     <= in_map;
			map_ok_s1  <= in_map_ok;
			now_s1     <= in_now;
			flag_s1    <= in_flag;
		end
	end

endmodule

// File: src/brbc_core.sv
// Decision logic and goal state of the bounded retry backoff controller.
// Evaluates one event against the bound goal and updates state; depends on brbc_pkg.
module brbc_core #(
	parameter int ID_WIDTH   = 32,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [TIME_WIDTH-1:0]         cfg_backoff,
	input  logic                          step,
	input  logic [brbc_pkg::MODE_W-1:0]   mode_s1,
	input  logic [ID_WIDTH-1:0]           task_s1,
	input  logic [ID_WIDTH-1:0]           request_s1,
	input  logic [brbc_pkg::EPOCH_W-1:0]  epoch_s1,
	input  logic [ID_WIDTH-1:0]           map_s1,
	input  logic                          map_ok_s1,
	input  logic [TIME_WIDTH-1:0]         now_s1,
	input  logic                          flag_s1,
	output brbc_pkg::rslt_t               rslt
);
	import brbc_pkg::*;

	// Configuration and goal state
	logic [TIME_WIDTH-1:0] backoff_q;
	logic                  goal_bound_q, goal_bound_d;
	logic [ID_WIDTH-1:0]   task_q, task_d;
	logic [ID_WIDTH-1:0]   request_q, request_d;
	logic [EPOCH_W-1:0]    epoch_q, epoch_d;
	logic [ID_WIDTH-1:0]   map_q, map_d;
	logic                  map_present_q, map_present_d;
	phase_t                phase_q, phase_d;
	logic                  budget_q, budget_d;
	logic                  start_q, start_d;
	logic [TIME_WIDTH-1:0] deadline_q, deadline_d;
	logic [TIME_WIDTH-1:0] last_time_q, last_time_d;
	logic                  time_present_q, time_present_d;
	reason_t               reason_q, reason_d;
	action_t               act;

	logic                  valid_goal, same_key, map_match, same_tok, active;
	logic                  regress, tok_arm, spent_arm;
	logic [TIME_WIDTH:0]   sum;
	reason_t               stale_reason;

	// Compare the event against the bound goal
	assign valid_goal = (task_s1 != '0) && (request_s1 != '0) && (epoch_s1 != '0)
		&& map_ok_s1;
	assign same_key   = goal_bound_q && (task_q == task_s1) && (request_q == request_s1);
	assign map_match  = map_present_q && map_ok_s1 && (map_q == map_s1);
	assign same_tok   = same_key && (epoch_q == epoch_s1) && map_match;
	assign active     = (phase_q == PH_BACKOFF) || (phase_q == PH_FLIGHT);
	assign regress    = time_present_q && (now_s1 < last_time_q);
	assign sum        = {1'b0, now_s1} + {1'b0, backoff_q};
	assign stale_reason = map_match ? RSN_STALE_EPOCH : RSN_STALE_MAP;
	// A fresh goal bound on arm counts as matching with an unspent budget
	assign tok_arm    = same_key ? same_tok : 1'b1;
	assign spent_arm  = same_key ? budget_q : 1'b0;

	// Next state and result for the event in the input stage
	always_comb begin
		goal_bound_d   = goal_bound_q;
		task_d         = task_q;
		request_d      = request_q;
		epoch_d        = epoch_q;
		map_d          = map_q;
		map_present_d  = map_present_q;
		phase_d        = phase_q;
		budget_d       = budget_q;
		start_d        = start_q;
		deadline_d     = deadline_q;
		last_time_d    = last_time_q;
		time_present_d = time_present_q;
		reason_d       = reason_q;
		act            = ACT_NONE;

		unique case (mode_t'(mode_s1))
			MODE_RESET: begin
				goal_bound_d   = 1'b0;
				task_d         = '0;
				request_d      = '0;
				epoch_d        = '0;
				map_d          = '0;
				map_present_d  = 1'b0;
				phase_d        = PH_IDLE;
				budget_d       = 1'b0;
				start_d        = 1'b0;
				deadline_d     = '0;
				last_time_d    = '0;
				time_present_d = 1'b0;
				reason_d       = RSN_NONE;
			end
			MODE_OBSERVE, MODE_ARM, MODE_TICK, MODE_COMPLETE, MODE_CANCEL: begin
				if (regress) begin
					// Time ran backwards: spend the attempt, keep the last time
					budget_d = 1'b1;
					start_d  = 1'b0;
					phase_d  = goal_bound_q ? PH_SPENT : PH_IDLE;
					reason_d = RSN_CLOCK_REGRESSION;
					act      = ACT_REJECT;
				end else begin
					last_time_d    = now_s1;
					time_present_d = 1'b1;
					case (mode_t'(mode_s1))
						MODE_OBSERVE: begin
							if (!valid_goal) begin
								budget_d = 1'b1;
								start_d  = 1'b0;
								phase_d  = goal_bound_q ? PH_SPENT : PH_IDLE;
								reason_d = RSN_INVALID_GOAL;
								act      = ACT_REJECT;
							end else if (!same_key) begin
								// Bind the new goal and drop any progress
								goal_bound_d  = 1'b1;
								task_d        = task_s1;
								request_d     = request_s1;
								epoch_d       = epoch_s1;
								map_d         = map_s1;
								map_present_d = 1'b1;
								phase_d       = PH_IDLE;
								budget_d      = 1'b0;
								start_d       = 1'b0;
								deadline_d    = '0;
								act      = (goal_bound_q && active) ? ACT_CANCEL : ACT_NONE;
								reason_d = (goal_bound_q && active) ? RSN_SUPERSEDED
									: RSN_NEW_GOAL;
							end else if (!map_match) begin
								if (active) begin
									budget_d = 1'b1;
									start_d  = 1'b0;
									phase_d  = PH_SPENT;
									reason_d = RSN_MAP_CHANGED;
									act      = ACT_CANCEL;
								end else begin
									reason_d = RSN_MAP_ADVANCED;
								end
								map_d         = map_s1;
								map_present_d = 1'b1;
								epoch_d       = epoch_s1;
							end else if (epoch_s1 != epoch_q) begin
								if (active) begin
									budget_d = 1'b1;
									start_d  = 1'b0;
									phase_d  = PH_SPENT;
									reason_d = RSN_EPOCH_CHANGED;
									act      = ACT_CANCEL;
								end else begin
									reason_d = RSN_EPOCH_ADVANCED;
								end
								epoch_d = epoch_s1;
							end else begin
								reason_d = RSN_UNCHANGED;
							end
						end
						MODE_ARM: begin
							if (!valid_goal) begin
								budget_d = 1'b1;
								start_d  = 1'b0;
								phase_d  = goal_bound_q ? PH_SPENT : PH_IDLE;
								reason_d = RSN_INVALID_GOAL;
								act      = ACT_REJECT;
							end else begin
								if (!same_key) begin
									goal_bound_d  = 1'b1;
									task_d        = task_s1;
									request_d     = request_s1;
									epoch_d       = epoch_s1;
									map_d         = map_s1;
									map_present_d = 1'b1;
									budget_d      = 1'b0;
									start_d       = 1'b0;
								end
								if (!tok_arm) begin
									budget_d = 1'b1;
									start_d  = 1'b0;
									phase_d  = PH_SPENT;
									reason_d = stale_reason;
									act      = ACT_CANCEL;
								end else if (spent_arm) begin
									if (phase_q == PH_BACKOFF) begin
										act      = ACT_HOLD;
										reason_d = RSN_BACKOFF_ALREADY;
									end else if (phase_q == PH_FLIGHT) begin
										act      = ACT_HOLD;
										reason_d = RSN_FLIGHT_ALREADY;
									end else begin
										act      = ACT_REJECT;
										reason_d = RSN_BUDGET_CONSUMED;
									end
								end else begin
									budget_d = 1'b1;
									if (!flag_s1) begin
										phase_d  = PH_SPENT;
										act      = ACT_CONSUME;
										reason_d = RSN_STOP_UNCONFIRMED;
									end else if (sum[TIME_WIDTH]) begin
										phase_d  = PH_SPENT;
										act      = ACT_REJECT;
										reason_d = RSN_DEADLINE_OVERFLOW;
									end else begin
										deadline_d = sum[TIME_WIDTH-1:0];
										phase_d    = PH_BACKOFF;
										start_d    = 1'b0;
										act        = ACT_HOLD;
										reason_d   = RSN_BACKOFF_PENDING;
									end
								end
							end
						end
						MODE_TICK: begin
							if (!same_key) begin
								act      = ACT_IGNORE;
								reason_d = RSN_TICK_UNKNOWN;
							end else if (!same_tok) begin
								budget_d = 1'b1;
								start_d  = 1'b0;
								phase_d  = PH_SPENT;
								reason_d = stale_reason;
								act      = ACT_CANCEL;
							end else if (phase_q != PH_BACKOFF) begin
								reason_d = RSN_NO_PENDING;
							end else if (now_s1 < deadline_q) begin
								act      = ACT_HOLD;
								reason_d = RSN_BACKOFF_PENDING;
							end else if (start_q) begin
								reason_d = RSN_START_ALREADY;
							end else begin
								start_d  = 1'b1;
								phase_d  = PH_FLIGHT;
								act      = ACT_START;
								reason_d = RSN_START_REPLAN;
							end
						end
						MODE_COMPLETE: begin
							if (!same_tok || (phase_q != PH_FLIGHT)) begin
								act      = ACT_IGNORE;
								reason_d = RSN_STALE_COMPLETION;
							end else begin
								phase_d  = PH_SPENT;
								act      = flag_s1 ? ACT_NONE : ACT_REJECT;
								reason_d = flag_s1 ? RSN_COMPLETED : RSN_FAILED;
							end
						end
						default: begin
							// Cancel
							if (!same_key) begin
								act      = ACT_IGNORE;
								reason_d = RSN_CANCEL_UNKNOWN;
							end else begin
								budget_d = 1'b1;
								start_d  = 1'b0;
								phase_d  = PH_SPENT;
								reason_d = RSN_CANCELLED;
								act      = ACT_CANCEL;
							end
						end
					endcase
				end
			end
			default: begin
				act = ACT_IGNORE;
			end
		endcase
	end

	// Snapshot after the event
	assign rslt.action      = act;
	assign rslt.reason      = reason_d;
	assign rslt.phase       = phase_d;
	assign rslt.budget_used = budget_d;
	assign rslt.start_sent  = start_d;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_q <= '0;
		end else if (cfg_wr) begin
			backoff_q <= cfg_backoff;
		end
	end

	// Advance goal state once per processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_bound_q   <= 1'b0;
			task_q         <= '0;
			request_q      <= '0;
			epoch_q        <= '0;
			map_q          <= '0;
			map_present_q  <= 1'b0;
			phase_q        <= PH_IDLE;
			budget_q       <= 1'b0;
			start_q        <= 1'b0;
			deadline_q     <= '0;
			last_time_q    <= '0;
			time_present_q <= 1'b0;
			reason_q       <= RSN_NONE;
		end else if (step) begin
			goal_bound_q   <= goal_bound_d;
			task_q         <= task_d;
			request_q      <= request_d;
			epoch_q        <= epoch_d;
			map_q          <= map_d;
			map_present_q  <= map_present_d;
			phase_q        <= phase_d;
			budget_q       <= budget_d;
			start_q        <= start_d;
			deadline_q     <= deadline_d;
			last_time_q    <= last_time_d;
			time_present_q <= time_present_d;
			reason_q       <= reason_d;
		end
	end

endmodule

// File: src/brbc_out_stage.sv
// Result register of the bounded retry backoff controller.
// Holds one result until the receiver takes it; depends on brbc_pkg.
module brbc_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  brbc_pkg::rslt_t rslt,
	output logic            step,
	output logic            out_valid,
	input  logic            out_ready,
	output brbc_pkg::rslt_t out_rslt
);
	import brbc_pkg::*;

	rslt_t rslt_s2;
	logic  valid_s2;

	// Advance when the result register is free or being emptied
	assign step = valid_s1 && (!valid_s2 || out_ready);

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Hold the result
	always_ff @(posedge clk) begin
		if (step) begin
			rslt_s2 <= rslt;
		end
	end

	assign out_valid = valid_s2;
	assign out_rslt  = rslt_s2;

endmodule

// File: src/bounded_retry_backoff_controller.sv
// Top level of the bounded retry backoff controller.
// Connects input stage, decision core and result register; depends on brbc_pkg, brbc_if.
//
// Usage:
//   item   - event requests (observe, arm, tick, complete, cancel, reset), one
//            result per request, in order.
//   result - action, reason code and a state snapshot taken after the event.
//   cfg    - write of backoff_ticks; always ready; write only while no request
//            is in progress.
// Pipeline: an accepted request passes two register stages, the input register
//   and then the result register.
// Throughput: one request per cycle while result.ready is high; the decision is a
//   single pass of compares and one add between the input and result registers.
// Reset: arst_n clears the goal, flags, deadline, time and backoff_ticks; the
//   block accepts requests right after reset.
// Stall: while result.ready is low the result register holds; the input
//   register still takes one more request, then item.ready drops until the
//   result is taken.
module bounded_retry_backoff_controller #(
	parameter int ID_WIDTH   = 32,
	parameter int TIME_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	brbc_event_if.sink    item,
	brbc_result_if.source result,
	brbc_cfg_if.sink      cfg
);
	import brbc_pkg::*;

	logic                  valid_s1, step;
	logic [MODE_W-1:0]     mode_s1;
	logic [ID_WIDTH-1:0]   task_s1, request_s1, map_s1;
	logic [EPOCH_W-1:0]    epoch_s1;
	logic                  map_ok_s1, flag_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	rslt_t                 rslt, out_rslt;

	assign cfg.ready = 1'b1;

	brbc_in_stage #(
		.ID_WIDTH  (ID_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_mode   (item.mode),
		.in_task   (item.task_key),
		.in_request(item.request_key),
		.in_epoch  (item.goal_epoch),
		.in_map    (item.map_key),
		.in_map_ok (item.map_key_valid),
		.in_now    (item.now_ticks),
		.in_flag   (item.event_flag),
		.step      (step),
		.valid_s1  (valid_s1),
		.mode_s1   (mode_s1),
		.task_s1   (task_s1),
		.request_s1(request_s1),
		.epoch_s1  (epoch_s1),
		.map_s1    (map_s1),
		.map_ok_s1 (map_ok_s1),
		.now_s1    (now_s1),
		.flag_s1   (flag_s1)
	);

	brbc_core #(
		.ID_WIDTH  (ID_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg.valid),
		.cfg_backoff(cfg.backoff_ticks),
		.step       (step),
		.mode_s1    (mode_s1),
		.task_s1    (task_s1),
		.request_s1 (request_s1),
		.epoch_s1   (epoch_s1),
		.map_s1     (map_s1),
		.map_ok_s1  (map_ok_s1),
		.now_s1     (now_s1),
		.flag_s1    (flag_s1),
		.rslt       (rslt)
	);

	brbc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.rslt     (rslt),
		.step     (step),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_rslt (out_rslt)
	);

	// Unpack the result onto the channel
	assign result.action       = out_rslt.action;
	assign result.reason_code  = out_rslt.reason;
	assign result.replan_state = out_rslt.phase;
	assign result.budget_used  = out_rslt.budget_used;
	assign result.start_sent   = out_rslt.start_sent;

endmodule

// File: bench/tb_bounded_retry_backoff_controller.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_retry_backoff_controller: a directed table, then random
// event sequences, checked against a cycle-free model of the retry decision.
// Depends on brbc_pkg, the brbc interfaces and the controller RTL.
module tb_bounded_retry_backoff_controller;
	import brbc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
	localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 4;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [31:0] task_key;
		logic [31:0] request_key;
		logic [31:0] goal_epoch;
		logic [31:0] map_key;
		logic map_key_valid;
		logic [31:0] now_ticks;
		logic event_flag;
	} ev_t;

	typedef enum {ROW_EVENT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		ev_t ev;
		bit typed;
		rslt_t want;
		logic [31:0] cfg_val;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	brbc_event_if #(.ID_WIDTH(32), .TIME_WIDTH(32)) item_ch();
	brbc_result_if res_ch();
	brbc_cfg_if #(.TIME_WIDTH(32)) cfg_ch();

	bounded_retry_backoff_controller #(.ID_WIDTH(32), .TIME_WIDTH(32)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// Model state of the controller
	logic [31:0] backoff_cfg;
	logic held;
	logic [31:0] g_task, g_req, g_epoch, g_map;
	logic g_map_ok;
	phase_t g_phase;
	logic spent, started;
	logic [31:0] due_at, seen_time;
	logic seen_time_ok;
	reason_t last_rsn;

	rslt_t awaited_results[$];
	row_t script[$];
	int errors = 0;
	int reports = 0;
	int events_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int starts_seen = 0;
	logic [31:0] reason_seen = '0;
	int idle_cycles = 0;

	// Random stimulus context
	logic [31:0] p_task[3], p_req[3], p_epoch[3], p_map[3];
	int cg = 0;
	logic [31:0] clock_now = '0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;
	int rx_span = 100;

	task automatic drop_progress();
		g_phase = PH_IDLE;
		spent = 1'b0;
		started = 1'b0;
		due_at = '0;
	endtask

	task automatic clear_goal();
		held = 1'b0;
		g_task = '0;
		g_req = '0;
		g_epoch = '0;
		g_map = '0;
		g_map_ok = 1'b0;
		drop_progress();
		seen_time = '0;
		seen_time_ok = 1'b0;
		last_rsn = RSN_NONE;
	endtask

	task automatic spend_attempt(input reason_t why);
		spent = 1'b1;
		started = 1'b0;
		g_phase = held ? PH_SPENT : PH_IDLE;
		last_rsn = why;
	endtask

	task automatic bind_goal(input ev_t ev);
		g_task = ev.task_key;
		g_req = ev.request_key;
		g_epoch = ev.goal_epoch;
		g_map = ev.map_key;
		g_map_ok = 1'b1;
		held = 1'b1;
	endtask

	// Advance the model by one event and return the result it calls for
	task automatic next_decision(input ev_t ev, output rslt_t r);
		logic valid_goal, key_hit, map_hit, tok_hit, busy, sup;
		logic [32:0] due_sum;
		action_t act;
		valid_goal = ev.task_key != 0 && ev.request_key != 0 && ev.goal_epoch != 0
			&& ev.map_key_valid;
		key_hit = held && g_task == ev.task_key && g_req == ev.request_key;
		map_hit = g_map_ok && ev.map_key_valid && g_map == ev.map_key;
		tok_hit = key_hit && g_epoch == ev.goal_epoch && map_hit;
		act = ACT_NONE;
		if (ev.mode >= MODE_UNDEF_LO) begin
			act = ACT_IGNORE;
		end else if (ev.mode == MODE_RESET) begin
			clear_goal();
		end else if (seen_time_ok && ev.now_ticks < seen_time) begin
			spend_attempt(RSN_CLOCK_REGRESSION);
			act = ACT_REJECT;
		end else begin
			seen_time = ev.now_ticks;
			seen_time_ok = 1'b1;
			busy = g_phase == PH_BACKOFF || g_phase == PH_FLIGHT;
			case (ev.mode)
				MODE_OBSERVE: begin
					if (!valid_goal) begin
						spend_attempt(RSN_INVALID_GOAL);
						act = ACT_REJECT;
					end else if (!key_hit) begin
						sup = held && busy;
						bind_goal(ev);
						drop_progress();
						act = sup ? ACT_CANCEL : ACT_NONE;
						last_rsn = sup ? RSN_SUPERSEDED : RSN_NEW_GOAL;
					end else if (!map_hit) begin
						if (busy) begin
							spend_attempt(RSN_MAP_CHANGED);
							act = ACT_CANCEL;
						end else begin
							last_rsn = RSN_MAP_ADVANCED;
						end
						g_map = ev.map_key;
						g_map_ok = 1'b1;
						g_epoch = ev.goal_epoch;
					end else if (ev.goal_epoch != g_epoch) begin
						if (busy) begin
							spend_attempt(RSN_EPOCH_CHANGED);
							act = ACT_CANCEL;
						end else begin
							last_rsn = RSN_EPOCH_ADVANCED;
						end
						g_epoch = ev.goal_epoch;
					end else begin
						last_rsn = RSN_UNCHANGED;
					end
				end
				MODE_ARM: begin
					if (!valid_goal) begin
						spend_attempt(RSN_INVALID_GOAL);
						act = ACT_REJECT;
					end else begin
						// A new goal on arm binds with a fresh budget
						if (!key_hit) begin
							bind_goal(ev);
							spent = 1'b0;
							started = 1'b0;
							tok_hit = 1'b1;
						end
						if (!tok_hit) begin
							spend_attempt(map_hit ? RSN_STALE_EPOCH : RSN_STALE_MAP);
							act = ACT_CANCEL;
						end else if (spent) begin
							if (g_phase == PH_BACKOFF) begin
								act = ACT_HOLD;
								last_rsn = RSN_BACKOFF_ALREADY;
							end else if (g_phase == PH_FLIGHT) begin
								act = ACT_HOLD;
								last_rsn = RSN_FLIGHT_ALREADY;
							end else begin
								act = ACT_REJECT;
								last_rsn = RSN_BUDGET_CONSUMED;
							end
						end else begin
							spent = 1'b1;
							due_sum = {1'b0, ev.now_ticks} + {1'b0, backoff_cfg};
							if (!ev.event_flag) begin
								g_phase = PH_SPENT;
								act = ACT_CONSUME;
								last_rsn = RSN_STOP_UNCONFIRMED;
							end else if (due_sum[32]) begin
								g_phase = PH_SPENT;
								act = ACT_REJECT;
								last_rsn = RSN_DEADLINE_OVERFLOW;
							end else begin
								due_at = due_sum[31:0];
								g_phase = PH_BACKOFF;
								started = 1'b0;
								act = ACT_HOLD;
								last_rsn = RSN_BACKOFF_PENDING;
							end
						end
					end
				end
				MODE_TICK: begin
					if (!key_hit) begin
						act = ACT_IGNORE;
						last_rsn = RSN_TICK_UNKNOWN;
					end else if (!tok_hit) begin
						spend_attempt(map_hit ? RSN_STALE_EPOCH : RSN_STALE_MAP);
						act = ACT_CANCEL;
					end else if (g_phase != PH_BACKOFF) begin
						last_rsn = RSN_NO_PENDING;
					end else if (ev.now_ticks < due_at) begin
						act = ACT_HOLD;
						last_rsn = RSN_BACKOFF_PENDING;
					end else if (started) begin
						last_rsn = RSN_START_ALREADY;
					end else begin
						started = 1'b1;
						g_phase = PH_FLIGHT;
						act = ACT_START;
						last_rsn = RSN_START_REPLAN;
					end
				end
				MODE_COMPLETE: begin
					if (!tok_hit || g_phase != PH_FLIGHT) begin
						act = ACT_IGNORE;
						last_rsn = RSN_STALE_COMPLETION;
					end else begin
						g_phase = PH_SPENT;
						act = ev.event_flag ? ACT_NONE : ACT_REJECT;
						last_rsn = ev.event_flag ? RSN_COMPLETED : RSN_FAILED;
					end
				end
				default: begin
					if (!key_hit) begin
						act = ACT_IGNORE;
						last_rsn = RSN_CANCEL_UNKNOWN;
					end else begin
						spend_attempt(RSN_CANCELLED);
						act = ACT_CANCEL;
					end
				end
			endcase
		end
		r.action = act;
		r.reason = last_rsn;
		r.phase = g_phase;
		r.budget_used = spent;
		r.start_sent = started;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 17)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tx_gap();
		if (tx_idle_on && $urandom_range(0, 1))
			return pick_gap();
		return 0;
	endfunction

	function automatic ev_t mk_ev(input logic [MODE_W-1:0] m, input logic [31:0] tk,
		input logic [31:0] rq, input logic [31:0] ep, input logic [31:0] mp, input logic mv,
		input logic [31:0] now, input logic fl);
		ev_t e;
		e = '{m, tk, rq, ep, mp, mv, now, fl};
		return e;
	endfunction

	function automatic rslt_t lit(input action_t a, input reason_t rs, input phase_t p,
		input int u, input int s);
		rslt_t r;
		r.action = a;
		r.reason = rs;
		r.phase = p;
		r.budget_used = u[0];
		r.start_sent = s[0];
		return r;
	endfunction

	task automatic ev_row(input ev_t e, input int typed, input rslt_t want);
		row_t row;
		row.kind = ROW_EVENT;
		row.ev = e;
		row.typed = typed[0];
		row.want = want;
		row.cfg_val = '0;
		script.push_back(row);
	endtask

	task automatic cfg_row(input logic [31:0] val);
		row_t row;
		row.kind = ROW_CFG;
		row.ev = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.cfg_val = val;
		script.push_back(row);
	endtask

	// Offer one request after a gap and hold it until accepted; call at a falling edge
	task automatic push_event(input ev_t ev, input int gap, input bit typed, input rslt_t want);
		rslt_t guess;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		{item_ch.mode, item_ch.task_key, item_ch.request_key, item_ch.goal_epoch,
			item_ch.map_key, item_ch.map_key_valid, item_ch.now_ticks,
			item_ch.event_flag} <= ev;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		next_decision(ev, guess);
		awaited_results.push_back(typed ? want : guess);
		events_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_backoff(input logic [31:0] val);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.backoff_ticks <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		backoff_cfg = val;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic refresh_goal(input int g);
		p_task[g] = $urandom;
		p_req[g] = $urandom;
		p_epoch[g] = $urandom_range(1, 50);
		p_map[g] = $urandom;
		if ($urandom_range(0, 3) == 0)
			p_epoch[g] = $urandom;
	endtask

	// Mostly well-formed traffic on a small pool of goals, with stale and noisy requests mixed in
	task automatic make_item(output ev_t ev);
		int pick, g, tweak;
		logic [32:0] step;
		logic [223:0] noise;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			cg = $urandom_range(0, 2);
		g = cg;
		if ($urandom_range(0, 99) == 0)
			refresh_goal(g);
		step = {1'b0, clock_now} + $urandom_range(0, 3);
		if (!step[32])
			clock_now = step[31:0];
		if ($urandom_range(0, 299) == 0)
			clock_now = $urandom;
		ev = mk_ev(MODE_TICK, p_task[g], p_req[g], p_epoch[g], p_map[g], 1'b1, clock_now,
			$urandom_range(0, 9) != 0);
		if (pick < 14) begin
			ev.mode = MODE_OBSERVE;
		end else if (pick < 30) begin
			ev.mode = MODE_ARM;
		end else if (pick < 62) begin
			ev.mode = MODE_TICK;
		end else if (pick < 75) begin
			ev.mode = MODE_COMPLETE;
			ev.event_flag = 1'($urandom_range(0, 1));
		end else if (pick < 79) begin
			ev.mode = MODE_CANCEL;
		end else if (pick < 81) begin
			ev.mode = MODE_RESET;
			clock_now = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom;
		end else if (pick < 83) begin
			ev = '0;
			ev.event_flag = 1'($urandom_range(0, 1));
			ev.mode = $urandom_range(0, 1) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
			ev.now_ticks = $urandom;
		end else if (pick < 92) begin
			ev.mode = MODE_W'($urandom_range(0, 3));
			tweak = $urandom_range(0, 5);
			case (tweak)
				0: ev.goal_epoch = ev.goal_epoch - 1;
				1: begin
					p_epoch[g] = p_epoch[g] + 1;
					ev.goal_epoch = p_epoch[g];
				end
				2: ev.map_key = ev.map_key ^ ($urandom | 32'd1);
				3: begin
					p_map[g] = $urandom;
					ev.map_key = p_map[g];
				end
				4: ev.map_key_valid = 1'b0;
				default: begin
					case ($urandom_range(0, 2))
						0: ev.task_key = '0;
						1: ev.request_key = '0;
						default: ev.goal_epoch = '0;
					endcase
				end
			endcase
		end else begin
			// Raw noise; follow its time forward so later traffic does not regress
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			ev = noise[$bits(ev_t)-1:0];
			ev.mode = MODE_W'($urandom_range(0, 7));
			if ($urandom_range(0, 1))
				ev.now_ticks = clock_now;
			if (ev.mode != MODE_RESET && ev.mode < MODE_UNDEF_LO && ev.now_ticks > clock_now)
				clock_now = ev.now_ticks;
		end
	endtask

	// Result side: random stalls, with stretches of steady readiness
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			res_ch.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			res_ch.ready <= 1'b1;
			if (rx_idle_on && $urandom_range(0, 3) == 0)
				rx_hold <= pick_gap();
		end
		if (rx_span == 0) begin
			rx_idle_on <= ~rx_idle_on;
			rx_span <= $urandom_range(20, 300);
		end else begin
			rx_span <= rx_span - 1;
		end
	end

	// Compare each returned result with the oldest one awaited
	always @(posedge clk) begin
		rslt_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.action, res_ch.reason_code, res_ch.replan_state, res_ch.budget_used,
				res_ch.start_sent};
			results_seen++;
			if (got.action == ACT_START)
				starts_seen++;
			reason_seen[got.reason] = 1'b1;
			if (awaited_results.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("%0t unexpected result a=%0d r=%0d s=%0d u=%0b g=%0b", $time,
						got.action, got.reason, got.phase, got.budget_used, got.start_sent);
				reports++;
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					errors++;
					if (reports < MAX_REPORTS)
						$display("%0t mismatch exp a=%0d r=%0d s=%0d u=%0b g=%0b %s",
							$time, want.action, want.reason, want.phase, want.budget_used,
							want.start_sent, $sformatf("got a=%0d r=%0d s=%0d u=%0b g=%0b",
							got.action, got.reason, got.phase, got.budget_used,
							got.start_sent));
					reports++;
				end
			end
		end
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_bounded_retry_backoff_controller failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		ev_t ev;
		logic [31:0] settings[PHASES];
		int directed;
		item_ch.valid = 1'b0;
		{item_ch.mode, item_ch.task_key, item_ch.request_key, item_ch.goal_epoch,
			item_ch.map_key, item_ch.map_key_valid, item_ch.now_ticks,
			item_ch.event_flag} = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.backoff_ticks = '0;
		backoff_cfg = '0;
		clear_goal();
		for (int g = 0; g < 3; g++)
			refresh_goal(g);

		// Unknown goal, invalid identity, then one full replan of an all-ones goal
		ev_row(mk_ev(MODE_TICK, 1, 1, 1, 1, 1'b1, 1, 1'b1), 1,
			lit(ACT_IGNORE, RSN_TICK_UNKNOWN, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_CANCEL, 1, 1, 1, 1, 1'b1, 1, 1'b0), 1,
			lit(ACT_IGNORE, RSN_CANCEL_UNKNOWN, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_COMPLETE, 1, 1, 1, 1, 1'b1, 1, 1'b1), 1,
			lit(ACT_IGNORE, RSN_STALE_COMPLETION, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_OBSERVE, 0, ALL1, ALL1, ALL1, 1'b1, 1, 1'b0), 1,
			lit(ACT_REJECT, RSN_INVALID_GOAL, PH_IDLE, 1, 0));
		ev_row(mk_ev(MODE_OBSERVE, ALL1, ALL1, ALL1, ALL1, 1'b1, 2, 1'b0), 1,
			lit(ACT_NONE, RSN_NEW_GOAL, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_OBSERVE, ALL1, ALL1, ALL1, ALL1, 1'b1, 3, 1'b1), 1,
			lit(ACT_NONE, RSN_UNCHANGED, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_ARM, ALL1, ALL1, ALL1, ALL1, 1'b1, 10, 1'b1), 1,
			lit(ACT_HOLD, RSN_BACKOFF_PENDING, PH_BACKOFF, 1, 0));
		ev_row(mk_ev(MODE_ARM, ALL1, ALL1, ALL1, ALL1, 1'b1, 10, 1'b1), 1,
			lit(ACT_HOLD, RSN_BACKOFF_ALREADY, PH_BACKOFF, 1, 0));
		ev_row(mk_ev(MODE_TICK, ALL1, ALL1, ALL1, ALL1, 1'b1, 10, 1'b0), 1,
			lit(ACT_START, RSN_START_REPLAN, PH_FLIGHT, 1, 1));
		ev_row(mk_ev(MODE_ARM, ALL1, ALL1, ALL1, ALL1, 1'b1, 11, 1'b1), 1,
			lit(ACT_HOLD, RSN_FLIGHT_ALREADY, PH_FLIGHT, 1, 1));
		ev_row(mk_ev(MODE_COMPLETE, ALL1, ALL1, ALL1, ALL1, 1'b1, 12, 1'b1), 1,
			lit(ACT_NONE, RSN_COMPLETED, PH_SPENT, 1, 1));
		ev_row(mk_ev(MODE_ARM, ALL1, ALL1, ALL1, ALL1, 1'b1, 20, 1'b1), 1,
			lit(ACT_REJECT, RSN_BUDGET_CONSUMED, PH_SPENT, 1, 1));
		ev_row(mk_ev(MODE_OBSERVE, ALL1, ALL1, ALL1, 0, 1'b1, 20, 1'b0), 1,
			lit(ACT_NONE, RSN_MAP_ADVANCED, PH_SPENT, 1, 1));
		ev_row(mk_ev(MODE_OBSERVE, ALL1, ALL1, 1, 0, 1'b1, 20, 1'b0), 1,
			lit(ACT_NONE, RSN_EPOCH_ADVANCED, PH_SPENT, 1, 1));
		ev_row(mk_ev(MODE_CANCEL, ALL1, ALL1, 1, 0, 1'b1, 20, 1'b0), 1,
			lit(ACT_CANCEL, RSN_CANCELLED, PH_SPENT, 1, 0));
		// Clock regression, then a reset event, an unconfirmed arm and the undefined modes
		ev_row(mk_ev(MODE_TICK, ALL1, ALL1, 1, 0, 1'b1, 5, 1'b0), 1,
			lit(ACT_REJECT, RSN_CLOCK_REGRESSION, PH_SPENT, 1, 0));
		ev_row(mk_ev(MODE_RESET, 0, 0, 0, 0, 1'b0, 0, 1'b0), 1,
			lit(ACT_NONE, RSN_NONE, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_OBSERVE, 1, 2, 1, 5, 1'b1, 0, 1'b0), 1,
			lit(ACT_NONE, RSN_NEW_GOAL, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_ARM, 1, 2, 1, 5, 1'b1, 0, 1'b0), 1,
			lit(ACT_CONSUME, RSN_STOP_UNCONFIRMED, PH_SPENT, 1, 0));
		ev_row(mk_ev(MODE_UNDEF_LO, 1, 2, 1, 5, 1'b1, 0, 1'b1), 1,
			lit(ACT_IGNORE, RSN_STOP_UNCONFIRMED, PH_SPENT, 1, 0));
		ev_row(mk_ev(MODE_UNDEF_HI, ALL1, ALL1, ALL1, ALL1, 1'b1, ALL1, 1'b1), 1,
			lit(ACT_IGNORE, RSN_STOP_UNCONFIRMED, PH_SPENT, 1, 0));
		// Largest backoff: overflowing deadline, then a pending backoff superseded
		cfg_row(ALL1);
		ev_row(mk_ev(MODE_OBSERVE, 7, 7, 3, 9, 1'b1, 1, 1'b0), 1,
			lit(ACT_NONE, RSN_NEW_GOAL, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_ARM, 7, 7, 3, 9, 1'b1, 1, 1'b1), 1,
			lit(ACT_REJECT, RSN_DEADLINE_OVERFLOW, PH_SPENT, 1, 0));
		ev_row(mk_ev(MODE_RESET, ALL1, ALL1, ALL1, ALL1, 1'b1, ALL1, 1'b1), 1,
			lit(ACT_NONE, RSN_NONE, PH_IDLE, 0, 0));
		ev_row(mk_ev(MODE_ARM, 3, 4, 2, 8, 1'b1, 0, 1'b1), 0, '0);
		ev_row(mk_ev(MODE_OBSERVE, 5, 6, 1, 8, 1'b1, 100, 1'b0), 1,
			lit(ACT_CANCEL, RSN_SUPERSEDED, PH_IDLE, 0, 0));

		settings = '{32'd5, 32'd0, 32'd1, ALL1, 32'd3, 32'h8000_0000, 32'd7, 32'hFFFF_FFFE};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_backoff(script[i].cfg_val);
			else
				push_event(script[i].ev, tx_gap(), script[i].typed, script[i].want);
		end
		directed = events_sent;

		// Random phases, one backoff setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			write_backoff(ph == PHASES - 1 ? $urandom_range(0, 10) : settings[ph]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) == 0)
					tx_idle_on = ~tx_idle_on;
				make_item(ev);
				push_event(ev, tx_gap(), 1'b0, '0);
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			errors += awaited_results.size();
			$display("%0d results never arrived", awaited_results.size());
		end
		$display("Sent %0d events (%0d directed) under %0d backoff writes; %0d results checked.",
			events_sent, directed, cfg_writes, results_seen);
		$display("Replans started: %0d; distinct reason codes returned: %0d.", starts_seen,
			$countones(reason_seen));
		if (errors == 0)
			$display("tb_bounded_retry_backoff_controller passed");
		else
			$display("tb_bounded_retry_backoff_controller failed");
		$finish;
	end

endmodule
